// ===== rtl/bre_pkg.sv =====
// Shared types and constants for the BER REAL encoder.
package bre_pkg;

  // Identifier octet after reset.
  localparam logic [7:0] TAG_RESET = 8'h09;

  // Special content octets.
  localparam logic [7:0] OCT_PLUS_INF  = 8'h40;
  localparam logic [7:0] OCT_MINUS_INF = 8'h41;
  localparam logic [7:0] OCT_NAN       = 8'h42;
  localparam logic [7:0] OCT_MINUS_ZRO = 8'h43;

  // Info octet for binary form, base 2, scale 0.
  localparam logic [7:0] INFO_POS  = 8'b1000_0000;
  localparam logic [7:0] INFO_NEG  = 8'b1100_0000;
  localparam logic [7:0] INFO_EXP2 = 8'b0000_0001;

  localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
  localparam logic [11:0] EXP_BIAS     = 12'd1075;
  localparam logic [11:0] EXP_SUBNORM  = 12'hBCE;  // -1074

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRIP,
    ST_FORM,
    ST_TAG,
    ST_LEN,
    ST_INFO,
    ST_EXP,
    ST_MANT
  } bre_state_t;

endpackage

// ===== rtl/ber_real_encoder.sv =====
// Top level: ASN.1 BER REAL encoder for binary64 bit patterns.
// Specials and zero go from IDLE straight to TAG; finite values first pass STRIP, which
//   drops one trailing zero bit of the mantissa per cycle (0..52 of them), and FORM.
// A new value is taken only in IDLE, once the last octet of the previous one is loaded;
//   octets leave one per cycle while m_tready holds, and the output stalls otherwise.
// Reset (rst, synchronous, active high): state to idle, output empty, real_tag to 9.
module ber_real_encoder
  import bre_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,     // real_tag
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,      // double_bits[63:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,      // out_byte[7:0]
  output logic        m_tlast       // last_byte
);

  bre_state_t state, state_next;

  logic [7:0]  real_tag;
  logic [52:0] mant;         // mantissa, shifted right one bit per cycle in STRIP while even
  logic [11:0] expo;         // signed exponent of the lsb of mant
  logic [7:0]  info;         // info octet, or the special octet
  logic [3:0]  clen;         // content length
  logic        exp_two;      // exponent takes two octets, first not yet sent
  logic [15:0] exp_sr;       // exponent octets, next one in the top byte
  logic [63:0] mant_sr;      // mantissa octets, left aligned
  logic [2:0]  mant_cnt;     // mantissa octets left after the current one

  logic        in_fire;
  logic        out_load;

  // input decode
  logic [10:0] in_ex;
  logic [51:0] in_frac;
  logic        in_special;   // one-octet content or empty content
  logic [7:0]  in_oct;
  logic [3:0]  in_clen;

  // normalize stage
  logic [63:0] n_form;
  logic [11:0] ev_form;
  logic        elen_two;
  logic [3:0]  nlen;
  logic [2:0]  align;

  // output selection
  logic        emit;
  logic [7:0]  byte_sel;
  logic        last_sel;

  assign in_fire  = s_tvalid && s_tready;
  assign out_load = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // Classify the incoming pattern.
  always_comb begin
    in_ex      = s_tdata[62:52];
    in_frac    = s_tdata[51:0];
    in_special = 1'b0;
    in_oct     = OCT_NAN;
    in_clen    = 4'd1;
    if (in_ex == EXP_ALL_ONES) begin
      in_special = 1'b1;
      if (in_frac != 52'd0) begin
        in_oct = OCT_NAN;
      end else begin
        in_oct = s_tdata[63] ? OCT_MINUS_INF : OCT_PLUS_INF;
      end
    end else if (in_ex == 11'd0 && in_frac == 52'd0) begin
      in_special = 1'b1;
      in_oct     = OCT_MINUS_ZRO;
      in_clen    = s_tdata[63] ? 4'd1 : 4'd0;
    end
  end

  // Odd mantissa and exponent to N and E: integral values move t mod 8 into N.
  always_comb begin
    if (expo[11]) begin
      n_form  = {11'd0, mant};
      ev_form = expo;
    end else begin
      n_form  = {11'd0, mant} << expo[2:0];
      ev_form = {expo[11:3], 3'b000};
    end
    elen_two = !((ev_form[11:7] == 5'b00000) || (ev_form[11:7] == 5'b11111));
    nlen = 4'd1;
    for (int k = 1; k < 8; k++) begin
      if ((n_form >> (8 * k - 1)) != 64'd0) begin
        nlen = nlen + 4'd1;
      end
    end
    align = 3'(4'd8 - nlen);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = in_special ? ST_TAG : ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (mant[0]) begin
          state_next = ST_FORM;
        end
      end
      ST_FORM: state_next = ST_TAG;
      ST_TAG: begin
        if (out_load) state_next = ST_LEN;
      end
      ST_LEN: begin
        if (out_load) state_next = (clen == 4'd0) ? ST_IDLE : ST_INFO;
      end
      ST_INFO: begin
        if (out_load) state_next = (clen == 4'd1) ? ST_IDLE : ST_EXP;
      end
      ST_EXP: begin
        if (out_load && !exp_two) state_next = ST_MANT;
      end
      ST_MANT: begin
        if (out_load && mant_cnt == 3'd0) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Octet offered to the output register.
  always_comb begin
    emit     = 1'b1;
    byte_sel = real_tag;
    last_sel = 1'b0;
    unique case (state)
      ST_TAG:  byte_sel = real_tag;
      ST_LEN: begin
        byte_sel = {4'd0, clen};
        last_sel = (clen == 4'd0);
      end
      ST_INFO: begin
        byte_sel = info;
        last_sel = (clen == 4'd1);
      end
      ST_EXP:  byte_sel = exp_sr[15:8];
      ST_MANT: begin
        byte_sel = mant_sr[63:56];
        last_sel = (mant_cnt == 3'd0);
      end
      ST_IDLE, ST_STRIP, ST_FORM: emit = 1'b0;
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      real_tag <= TAG_RESET;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        real_tag <= cfg_data;
      end
      if (out_load) begin
        m_tvalid <= emit;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= byte_sel;
      m_tlast <= last_sel;
    end
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          info <= in_special ? in_oct : (s_tdata[63] ? INFO_NEG : INFO_POS);
          clen <= in_clen;
          if (in_ex == 11'd0) begin
            mant <= {1'b0, in_frac};
            expo <= EXP_SUBNORM;
          end else begin
            mant <= {1'b1, in_frac};
            expo <= {1'b0, in_ex} - EXP_BIAS;
          end
        end
      end
      ST_STRIP: begin
        if (!mant[0]) begin
          mant <= {1'b0, mant[52:1]};
          expo <= expo + 12'd1;
        end
      end
      ST_FORM: begin
        info     <= info | (elen_two ? INFO_EXP2 : 8'h00);
        clen     <= 4'd1 + (elen_two ? 4'd2 : 4'd1) + nlen;
        exp_two  <= elen_two;
        exp_sr   <= elen_two ? {{4{ev_form[11]}}, ev_form} : {ev_form[7:0], 8'h00};
        mant_sr  <= n_form << {align, 3'b000};
        mant_cnt <= 3'(nlen - 4'd1);
      end
      ST_EXP: begin
        if (out_load) begin
          exp_sr  <= {exp_sr[7:0], 8'h00};
          exp_two <= 1'b0;
        end
      end
      ST_MANT: begin
        if (out_load) begin
          mant_sr  <= {mant_sr[55:0], 8'h00};
          mant_cnt <= mant_cnt - 3'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/bre_checker.sv =====
// Port-level checks for the BER REAL encoder, bound to the top level.
module bre_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast
);

  // A stalled octet holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output octet changed while stalled");

  // One value in flight: no input transfer right after another.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a value is in work");

  // While ready for a new value, only the final octet of the last one may wait.
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    s_tready && m_tvalid |-> m_tlast)
    else $error("ready with a non-final octet pending");

  // Reset empties the output.
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind ber_real_encoder bre_checker u_bre_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ===== bench/tb_ber_real_encoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ber_real_encoder: binary64 in, BER REAL octets out.
module tb_ber_real_encoder;
  import bre_pkg::*;

  // No-transfer cycles tolerated before the run is declared hung. The longest
  // legal quiet stretch is a 52-bit strip plus a phase change; this is far above it.
  localparam int STALL_LIMIT      = 2000;
  // Settle time after the last octet; covers the worst first-octet latency.
  localparam int SETTLE_CYCLES    = 80;
  localparam int RANDOM_PER_PHASE = 145;

  typedef struct packed {
    logic [63:0] bits;
    logic        hold;   // wait for the encoder to go quiet before sending
  } double_item_t;

  typedef struct packed {
    logic [7:0] octet;
    logic       last;
  } ber_octet_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        cfg_we   = 1'b0;
  logic [7:0]  cfg_data = 8'h00;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = 64'h0;   // double_bits[63:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;            // out_byte[7:0]
  logic        m_tlast;            // last_byte

  double_item_t pending_doubles[$];
  ber_octet_t   expected_octets[$];
  ber_octet_t   next_octet;

  logic [7:0] tag_model      = TAG_RESET;
  int         send_idle_pct  = 19;
  int         recv_stall_pct = 46;
  logic       calm           = 1'b0;
  logic [6:0] calm_count     = 7'd0;
  int         errors         = 0;
  int         quiet_cycles   = 0;

  ber_real_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    errors++;
  endtask

  // Builds the full encoding of one binary64 pattern (tag, length, content)
  // and appends it to the expected octet stream.
  function automatic void encode_ber_real(input logic [63:0] bits);
    logic        neg;
    logic [10:0] ex;
    logic [51:0] frac;
    logic [63:0] m;
    logic [63:0] n;
    logic [15:0] ev_bits;
    logic [7:0]  octets [0:12];
    int          e, t, ev, tz, elen, nlen, clen, k;
    neg  = bits[63];
    ex   = bits[62:52];
    frac = bits[51:0];
    clen = 0;
    if (ex == EXP_ALL_ONES) begin
      // infinities and every NaN collapse to one special octet
      octets[2] = (frac != 52'd0) ? OCT_NAN : (neg ? OCT_MINUS_INF : OCT_PLUS_INF);
      clen = 1;
    end else if (ex == 11'd0 && frac == 52'd0) begin
      // +0 has empty content, -0 gets its own octet
      if (neg) begin
        octets[2] = OCT_MINUS_ZRO;
        clen = 1;
      end
    end else begin
      if (ex == 11'd0) begin
        m = {12'd0, frac};       // subnormal: no hidden bit
        e = -1074;
      end else begin
        m = {11'd0, 1'b1, frac};
        e = ex;
        e = e - 1075;
      end
      tz = 0;
      while (m[0] == 1'b0 && tz < 63) begin
        m = m >> 1;
        tz++;
      end
      t = tz + e;
      // integral values keep E a multiple of 8 and push the rest into N
      if (t >= 0) begin
        n  = m << (t % 8);
        ev = (t / 8) * 8;
      end else begin
        n  = m;
        ev = t;
      end
      elen = (ev >= -128 && ev <= 127) ? 1 : 2;
      nlen = 1;
      while (nlen < 8 && (n >> (8 * nlen - 1)) != 64'd0) nlen++;
      ev_bits   = ev[15:0];
      octets[2] = (neg ? INFO_NEG : INFO_POS) | ((elen == 2) ? INFO_EXP2 : 8'h00);
      clen      = 1;
      if (elen == 2) begin
        octets[2 + clen] = ev_bits[15:8];
        clen++;
      end
      octets[2 + clen] = ev_bits[7:0];
      clen++;
      for (k = nlen; k > 0; k--) begin
        octets[2 + clen] = 8'(n >> (8 * (k - 1)));
        clen++;
      end
    end
    octets[0] = tag_model;
    octets[1] = 8'(clen);
    for (k = 0; k < clen + 2; k++)
      expected_octets.push_back('{octet: octets[k], last: (k == clen + 1)});
  endfunction

  // Random binary64 patterns, biased toward integers, exponent extremes,
  // specials and sparse mantissas (long trailing-zero strips).
  function automatic logic [63:0] random_double();
    logic        neg;
    logic [10:0] ex;
    logic [51:0] frac;
    neg  = 1'($urandom_range(0, 1));
    ex   = 11'($urandom_range(0, 2047));
    frac = 52'({$urandom, $urandom});
    case ($urandom_range(0, 5))
      0: begin
        return {$urandom, $urandom};
      end
      1: begin
        ex   = 11'(1023 + $urandom_range(0, 62));
        frac = frac & ({52{1'b1}} << $urandom_range(0, 52));
      end
      2: begin
        case ($urandom_range(0, 3))
          0:       ex = 11'd0;
          1:       ex = 11'd1;
          2:       ex = 11'h7FE;
          default: ex = EXP_ALL_ONES;
        endcase
        if ($urandom_range(0, 3) == 0) frac = 52'd0;
      end
      3: begin
        frac = (52'd1 << $urandom_range(0, 51)) | (52'd1 << $urandom_range(0, 51));
      end
      4: begin
        frac = frac & ({52{1'b1}} << $urandom_range(0, 52));
      end
      default: ;
    endcase
    return {neg, ex, frac};
  endfunction

  // Now and then, whenever calm_count wraps, flip into an idle-free stretch.
  always @(posedge clk) begin
    calm_count <= calm_count + 7'd1;
    if (calm_count == 7'd0) calm <= ($urandom_range(0, 3) == 0);
  end

  // Driver: presents the head of pending_doubles, predicts on each transfer.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) encode_ber_real(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (pending_doubles.size() != 0 &&
            !(pending_doubles[0].hold && expected_octets.size() != 0) &&
            (calm || $urandom_range(0, 99) >= send_idle_pct)) begin
          s_tdata  <= pending_doubles[0].bits;
          s_tvalid <= 1'b1;
          void'(pending_doubles.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    m_tready <= !rst && (calm || $urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: every output transfer is matched against the oldest expected octet.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_octets.size() == 0) begin
        report_mismatch($sformatf("octet %02h with nothing expected", m_tdata));
      end else begin
        next_octet = expected_octets.pop_front();
        if (m_tdata !== next_octet.octet)
          report_mismatch($sformatf("octet %02h, expected %02h", m_tdata, next_octet.octet));
        if (m_tlast !== next_octet.last)
          report_mismatch($sformatf("tlast %b, expected %b (octet %02h)",
                                    m_tlast, next_octet.last, next_octet.octet));
      end
    end
  end

  // Watchdog: too long without any transfer means the encoder is stuck.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("[ber_real_encoder] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Waits until everything queued has gone in and every octet has come out.
  task automatic wait_for_idle();
    while (pending_doubles.size() != 0 || s_tvalid || expected_octets.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_tag(input logic [7:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_data  <= value;
    tag_model = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++)
      pending_doubles.push_back('{bits: random_double(), hold: ($urandom_range(0, 49) == 0)});
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: zeros, specials, subnormal and normal extremes, integer
    // stripping, two-octet exponents. Tag left at its reset value.
    pending_doubles.push_back('{64'h0000000000000000, 1'b0});  // +0
    pending_doubles.push_back('{64'h8000000000000000, 1'b0});  // -0
    pending_doubles.push_back('{64'h7FF0000000000000, 1'b0});  // +inf
    pending_doubles.push_back('{64'hFFF0000000000000, 1'b0});  // -inf
    pending_doubles.push_back('{64'h7FF8000000000000, 1'b0});  // quiet NaN
    pending_doubles.push_back('{64'hFFF0000000000001, 1'b0});  // negative NaN, payload 1
    pending_doubles.push_back('{64'hFFFFFFFFFFFFFFFF, 1'b0});  // all ones: NaN
    pending_doubles.push_back('{64'h3FF0000000000000, 1'b0});  // 1.0
    pending_doubles.push_back('{64'hBFF0000000000000, 1'b0});  // -1.0
    pending_doubles.push_back('{64'h3FE0000000000000, 1'b0});  // 0.5
    pending_doubles.push_back('{64'h4070000000000000, 1'b1});  // 256.0, one octet stripped
    pending_doubles.push_back('{64'h4060000000000000, 1'b0});  // 128.0, N needs sign octet
    pending_doubles.push_back('{64'hC06FE00000000000, 1'b0});  // -255.0
    pending_doubles.push_back('{64'h4008000000000000, 1'b0});  // 3.0
    pending_doubles.push_back('{64'h3FF8000000000000, 1'b0});  // 1.5
    pending_doubles.push_back('{64'h3FB999999999999A, 1'b0});  // 0.1, full mantissa
    pending_doubles.push_back('{64'h4330000000000001, 1'b0});  // 2^52 + 1
    pending_doubles.push_back('{64'h43E0000000000000, 1'b0});  // 2^63
    pending_doubles.push_back('{64'h7FEFFFFFFFFFFFFF, 1'b0});  // largest finite
    pending_doubles.push_back('{64'hFFEFFFFFFFFFFFFF, 1'b0});  // most negative finite
    pending_doubles.push_back('{64'h7FE0000000000000, 1'b0});  // 2^1023, E = 1016
    pending_doubles.push_back('{64'h0010000000000000, 1'b0});  // smallest normal
    pending_doubles.push_back('{64'h000FFFFFFFFFFFFF, 1'b0});  // largest subnormal
    pending_doubles.push_back('{64'h0000000000000001, 1'b0});  // smallest subnormal
    pending_doubles.push_back('{64'h8000000000000001, 1'b0});  // negative smallest subnormal
    pending_doubles.push_back('{64'h3370000000000000, 1'b0});  // 2^-200, two-octet E
    wait_for_idle();

    // Sender 19% idle, receiver 46% stalled, tag at its low extreme.
    write_tag(8'h00);
    queue_random(RANDOM_PER_PHASE);
    wait_for_idle();

    // Roles swapped, tag at its high extreme.
    send_idle_pct  = 46;
    recv_stall_pct = 19;
    write_tag(8'hFF);
    queue_random(RANDOM_PER_PHASE);
    wait_for_idle();

    // Full rate on both sides, arbitrary tag.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_tag(8'($urandom_range(1, 254)));
    queue_random(RANDOM_PER_PHASE);
    wait_for_idle();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_octets.size() != 0)
      report_mismatch($sformatf("%0d octets never arrived", expected_octets.size()));
    if (errors == 0) begin
      $display("[ber_real_encoder] OK");
    end else begin
      $display("[ber_real_encoder] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bre_pkg.sv
rtl/ber_real_encoder.sv
rtl/bre_checker.sv
bench/tb_ber_real_encoder.sv
